// File: sv/sit_pkg.sv
// Package for the segment intersection test core.
// Holds the default coordinate width and the orientation flag type.
// No dependencies.
package sit_pkg;

	// Default coordinate width in bits, two's complement.
	localparam int COORD_WIDTH_DEF = 16;

	// Number of orientation tests run on each pair of segments.
	localparam int NUM_TESTS = 4;

	// Orientation of a point against a segment, held as two flags.
	// pos set means +1, zero set means 0, neither set means -1.
	typedef struct packed {
		logic pos;
		logic zero;
	} orient_t;

endpackage

// File: sv/segment_intersection_test_core.sv
// Segment intersection test: top level, a four-stage pipeline.
// Depends on sit_pkg.
//
//  Channel  Signals                                  Direction  Carries
//  input    in_valid, in_ready, a_*_x/y, b_*_x/y     in         one pair of segments
//  output   out_valid, out_ready, intersects         out        one verdict per pair
//
// One pair is taken in every cycle while in_ready is high. Its verdict passes through the
// four register stages and is offered on out_valid from stage four, where it stays until
// the output side takes it; the multipliers of stage two set the clock period.
// Reset (arst_n, asynchronous, active low) empties the pipeline; data registers keep
// whatever they hold. A stall at the output fills empty stages first, so bubbles
// close up and in_ready only falls once all four stages hold a pair.
module segment_intersection_test_core
	import sit_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] a_start_x,
	input  logic signed [COORD_WIDTH-1:0] a_start_y,
	input  logic signed [COORD_WIDTH-1:0] a_end_x,
	input  logic signed [COORD_WIDTH-1:0] a_end_y,
	input  logic signed [COORD_WIDTH-1:0] b_start_x,
	input  logic signed [COORD_WIDTH-1:0] b_start_y,
	input  logic signed [COORD_WIDTH-1:0] b_end_x,
	input  logic signed [COORD_WIDTH-1:0] b_end_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          intersects
);

	// Differences need one bit more than a coordinate, products twice that,
	// and the sums of two squares one bit more again.
	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 1;

	// ------------------------------------------------------------------
	// Flow control. A stage may load when it is empty or when the stage
	// after it loads in the same cycle.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic ld_s1, ld_s2, ld_s3, ld_s4;

	assign ld_s4    = !v_s4 || out_ready;
	assign ld_s3    = !v_s3 || ld_s4;
	assign ld_s2    = !v_s2 || ld_s3;
	assign ld_s1    = !v_s1 || ld_s2;
	assign in_ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld_s1) begin
				v_s1 <= in_valid;
			end
			if (ld_s2) begin
				v_s2 <= v_s1;
			end
			if (ld_s3) begin
				v_s3 <= v_s2;
			end
			if (ld_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test set-up. Tests 0 and 1 place the start and end of B against
	// segment A; tests 2 and 3 place the start and end of A against B.
	// ------------------------------------------------------------------
	logic signed [COORD_WIDTH-1:0] sx_c [NUM_TESTS];
	logic signed [COORD_WIDTH-1:0] sy_c [NUM_TESTS];
	logic signed [COORD_WIDTH-1:0] ex_c [NUM_TESTS];
	logic signed [COORD_WIDTH-1:0] ey_c [NUM_TESTS];
	logic signed [COORD_WIDTH-1:0] px_c [NUM_TESTS];
	logic signed [COORD_WIDTH-1:0] py_c [NUM_TESTS];

	always_comb begin
		sx_c[0] = a_start_x; sy_c[0] = a_start_y; ex_c[0] = a_end_x; ey_c[0] = a_end_y;
		px_c[0] = b_start_x; py_c[0] = b_start_y;
		sx_c[1] = a_start_x; sy_c[1] = a_start_y; ex_c[1] = a_end_x; ey_c[1] = a_end_y;
		px_c[1] = b_end_x;   py_c[1] = b_end_y;
		sx_c[2] = b_start_x; sy_c[2] = b_start_y; ex_c[2] = b_end_x; ey_c[2] = b_end_y;
		px_c[2] = a_start_x; py_c[2] = a_start_y;
		sx_c[3] = b_start_x; sy_c[3] = b_start_y; ex_c[3] = b_end_x; ey_c[3] = b_end_y;
		px_c[3] = a_end_x;   py_c[3] = a_end_y;
	end

	// Stage 1 holds the direction vector u = E - S and the offset v = P - S.
	logic signed [DW-1:0] ux_s1 [NUM_TESTS];
	logic signed [DW-1:0] uy_s1 [NUM_TESTS];
	logic signed [DW-1:0] vx_s1 [NUM_TESTS];
	logic signed [DW-1:0] vy_s1 [NUM_TESTS];

	// Stage 2 holds the two cross-product terms, the four squares and a flag
	// that says P lies behind S along some axis.
	logic signed [PW-1:0] l_s2   [NUM_TESTS];
	logic signed [PW-1:0] r_s2   [NUM_TESTS];
	logic signed [PW-1:0] uxx_s2 [NUM_TESTS];
	logic signed [PW-1:0] uyy_s2 [NUM_TESTS];
	logic signed [PW-1:0] vxx_s2 [NUM_TESTS];
	logic signed [PW-1:0] vyy_s2 [NUM_TESTS];
	logic                 behind_s2 [NUM_TESTS];

	// Stage 3 holds the orientation of each test.
	orient_t o_s3 [NUM_TESTS];

	for (genvar k = 0; k < NUM_TESTS; k++) begin : g_test
		logic                 back_x_c, back_y_c;
		logic                 gt_c, lt_c, longer_c;
		logic [SW-1:0]        su_c, sv_c;

		// P is behind S on an axis when u and v point opposite ways on it,
		// both being non-zero.
		assign back_x_c = (ux_s1[k][DW-1] != vx_s1[k][DW-1])
			&& (ux_s1[k] != '0) && (vx_s1[k] != '0);
		assign back_y_c = (uy_s1[k][DW-1] != vy_s1[k][DW-1])
			&& (uy_s1[k] != '0) && (vy_s1[k] != '0);

		// Squares are never negative, so the sums are taken unsigned.
		assign su_c = {1'b0, uxx_s2[k]} + {1'b0, uyy_s2[k]};
		assign sv_c = {1'b0, vxx_s2[k]} + {1'b0, vyy_s2[k]};
		assign gt_c = l_s2[k] > r_s2[k];
		assign lt_c = l_s2[k] < r_s2[k];
		assign longer_c = su_c < sv_c;

		always_ff @(posedge clk) begin
			if (ld_s1) begin
				ux_s1[k] <= DW'(ex_c[k]) - DW'(sx_c[k]);
				uy_s1[k] <= DW'(ey_c[k]) - DW'(sy_c[k]);
				vx_s1[k] <= DW'(px_c[k]) - DW'(sx_c[k]);
				vy_s1[k] <= DW'(py_c[k]) - DW'(sy_c[k]);
			end
			if (ld_s2) begin
				l_s2[k]      <= PW'(ux_s1[k]) * PW'(vy_s1[k]);
				r_s2[k]      <= PW'(uy_s1[k]) * PW'(vx_s1[k]);
				uxx_s2[k]    <= PW'(ux_s1[k]) * PW'(ux_s1[k]);
				uyy_s2[k]    <= PW'(uy_s1[k]) * PW'(uy_s1[k]);
				vxx_s2[k]    <= PW'(vx_s1[k]) * PW'(vx_s1[k]);
				vyy_s2[k]    <= PW'(vy_s1[k]) * PW'(vy_s1[k]);
				behind_s2[k] <= back_x_c || back_y_c;
			end
			if (ld_s3) begin
				// Left of the segment, or collinear and beyond its end, gives +1.
				o_s3[k].pos  <= gt_c || (!lt_c && !behind_s2[k] && longer_c);
				o_s3[k].zero <= !gt_c && !lt_c && !behind_s2[k] && !longer_c;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: a product of two orientations is at most zero when either
	// is zero or their signs differ.
	// ------------------------------------------------------------------
	logic pa_ok_c, pb_ok_c;
	logic intersects_s4;

	assign pa_ok_c = o_s3[0].zero || o_s3[1].zero || (o_s3[0].pos != o_s3[1].pos);
	assign pb_ok_c = o_s3[2].zero || o_s3[3].zero || (o_s3[2].pos != o_s3[3].pos);

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			intersects_s4 <= pa_ok_c && pb_ok_c;
		end
	end

	assign out_valid  = v_s4;
	assign intersects = intersects_s4;

endmodule

// File: sv/sit_checker.sv
// Port-level checker for the segment intersection test core, with its bind.
// Depends on sit_pkg and on segment_intersection_test_core.
module sit_checker
	import sit_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic signed [COORD_WIDTH-1:0] a_start_x,
	input logic signed [COORD_WIDTH-1:0] a_start_y,
	input logic signed [COORD_WIDTH-1:0] a_end_x,
	input logic signed [COORD_WIDTH-1:0] a_end_y,
	input logic signed [COORD_WIDTH-1:0] b_start_x,
	input logic signed [COORD_WIDTH-1:0] b_start_y,
	input logic signed [COORD_WIDTH-1:0] b_end_x,
	input logic signed [COORD_WIDTH-1:0] b_end_y,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          intersects
);

	// The pipeline is empty after any clock edge taken in reset.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("out_valid high after a reset edge");

	// A waiting input transfer keeps its valid and its payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> (in_valid && $stable({a_start_x, a_start_y,
			a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y})))
		else $error("waiting input transfer changed or vanished");

	// The input side only blocks when every stage is full and the output stalls.
	a_block_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("in_ready low without an output stall");

	// Without stalls a verdict appears on out_valid once it has passed through every stage.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("verdict missing four cycles after transfer");

	// A stalled verdict holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(intersects)))
		else $error("stalled verdict changed or vanished");

endmodule

bind segment_intersection_test_core sit_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sit_checker (.*);

// File: sim/segment_intersection_test_core_test.sv
// Testbench for segment_intersection_test_core: random and directed segment pairs,
// verdicts checked in order against a predictor held in this file.
// Depends on sit_pkg and segment_intersection_test_core.
module segment_intersection_test_core_test;
	import sit_pkg::*;

	localparam int COORD_W = COORD_WIDTH_DEF;
	localparam int RANDOM_PAIRS = 1300;
	// The limit leaves a wide margin above the slowest correct run, even with the longest
	// gaps and stalls on every pair.
	localparam int CYCLE_LIMIT = 500000;
	// The pipeline is four stages deep, so the DRAIN_CYCLES idle cycles at the end are ample
	// for any stray verdict to show itself.
	localparam int DRAIN_CYCLES = 20;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t a_start_x;
		coord_t a_start_y;
		coord_t a_end_x;
		coord_t a_end_y;
		coord_t b_start_x;
		coord_t b_start_y;
		coord_t b_end_x;
		coord_t b_end_y;
	} seg_pair_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	coord_t a_start_x = '0;
	coord_t a_start_y = '0;
	coord_t a_end_x = '0;
	coord_t a_end_y = '0;
	coord_t b_start_x = '0;
	coord_t b_start_y = '0;
	coord_t b_end_x = '0;
	coord_t b_end_y = '0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	logic   intersects;

	seg_pair_t pending_pairs[$];
	logic      expected_verdicts[$];
	int        error_count = 0;
	int        cycle_count = 0;

	segment_intersection_test_core #(
		.COORD_WIDTH(COORD_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.a_start_x(a_start_x),
		.a_start_y(a_start_y),
		.a_end_x(a_end_x),
		.a_end_y(a_end_y),
		.b_start_x(b_start_x),
		.b_start_y(b_start_y),
		.b_end_x(b_end_x),
		.b_end_y(b_end_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.intersects(intersects)
	);

	always #5 clk = ~clk;

	// Counter-clockwise orientation of point P against segment S->E.
	// Off the line the sign of the cross product decides. On the line, a point
	// behind S gives -1, a point beyond E (judged by squared distance from S)
	// gives +1, and anything between gives 0. A segment that is a single point
	// therefore yields 0 only for that very point. Every product is compared,
	// never subtracted, so 64-bit arithmetic is exact for any width up to 31.
	function automatic int orientation(longint sx, longint sy, longint ex, longint ey,
			longint px, longint py);
		longint ux, uy, vx, vy, lhs, rhs;
		ux = ex - sx;
		uy = ey - sy;
		vx = px - sx;
		vy = py - sy;
		lhs = ux * vy;
		rhs = uy * vx;
		if (lhs > rhs) return 1;
		if (lhs < rhs) return -1;
		if (ux * vx < 0 || uy * vy < 0) return -1;
		if (ux * ux + uy * uy < vx * vx + vy * vy) return 1;
		return 0;
	endfunction

	// The segments meet when neither segment has both ends of the other strictly
	// on one side of it.
	function automatic logic predict_intersects(seg_pair_t p);
		int side_a, side_b;
		side_a = orientation(p.a_start_x, p.a_start_y, p.a_end_x, p.a_end_y,
				p.b_start_x, p.b_start_y) *
			orientation(p.a_start_x, p.a_start_y, p.a_end_x, p.a_end_y,
				p.b_end_x, p.b_end_y);
		side_b = orientation(p.b_start_x, p.b_start_y, p.b_end_x, p.b_end_y,
				p.a_start_x, p.a_start_y) *
			orientation(p.b_start_x, p.b_start_y, p.b_end_x, p.b_end_y,
				p.a_end_x, p.a_end_y);
		return (side_a <= 0 && side_b <= 0);
	endfunction

	function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
			int bx0, int by0, int bx1, int by1);
		seg_pair_t p;
		p.a_start_x = coord_t'(ax0);
		p.a_start_y = coord_t'(ay0);
		p.a_end_x   = coord_t'(ax1);
		p.a_end_y   = coord_t'(ay1);
		p.b_start_x = coord_t'(bx0);
		p.b_start_y = coord_t'(by0);
		p.b_end_x   = coord_t'(bx1);
		p.b_end_y   = coord_t'(by1);
		return p;
	endfunction

	function automatic int grid_coord();
		return int'($urandom_range(0, 16)) - 8;
	endfunction

	function automatic int line_step();
		return int'($urandom_range(0, 10)) - 4;
	endfunction

	function automatic int extreme_coord();
		int picks[7];
		picks = '{-32768, -32767, -1, 0, 1, 32766, 32767};
		return picks[$urandom_range(0, 6)];
	endfunction

	// Four endpoints around a base point, each x a whole multiple of dx and each y a whole
	// multiple of dy away from it, the multiples drawn independently, so they are sure to lie
	// on one line only when dx or dy is zero. That case reaches overlap, containment, touching
	// ends and disjoint collinear segments, and a zero direction gives coincident points.
	function automatic seg_pair_t collinear_pair();
		int span, base_x, base_y, dx, dy;
		span = ($urandom_range(0, 3) == 0) ? 1500 : 5;
		base_x = int'($urandom_range(0, 2000)) - 1000;
		base_y = int'($urandom_range(0, 2000)) - 1000;
		dx = int'($urandom_range(0, 2 * span)) - span;
		dy = int'($urandom_range(0, 2 * span)) - span;
		return make_pair(base_x + line_step() * dx, base_y + line_step() * dy,
			base_x + line_step() * dx, base_y + line_step() * dy,
			base_x + line_step() * dx, base_y + line_step() * dy,
			base_x + line_step() * dx, base_y + line_step() * dy);
	endfunction

	function automatic seg_pair_t random_pair();
		seg_pair_t p;
		int mode;
		mode = $urandom_range(0, 99);
		if (mode < 25) begin
			p = make_pair($urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom(), $urandom());
		end else if (mode < 50) begin
			p = make_pair(grid_coord(), grid_coord(), grid_coord(), grid_coord(),
				grid_coord(), grid_coord(), grid_coord(), grid_coord());
		end else if (mode < 70) begin
			p = collinear_pair();
		end else if (mode < 80) begin
			// One endpoint of B lands on an endpoint of A.
			p = make_pair(grid_coord(), grid_coord(), grid_coord(), grid_coord(),
				grid_coord(), grid_coord(), grid_coord(), grid_coord());
			if ($urandom_range(0, 1) == 0) begin
				p.b_start_x = $urandom_range(0, 1) ? p.a_start_x : p.a_end_x;
				p.b_start_y = (p.b_start_x == p.a_start_x) ? p.a_start_y : p.a_end_y;
			end else begin
				p.b_end_x = $urandom_range(0, 1) ? p.a_start_x : p.a_end_x;
				p.b_end_y = (p.b_end_x == p.a_start_x) ? p.a_start_y : p.a_end_y;
			end
		end else if (mode < 90) begin
			// Collapse A, and sometimes B too, to a single point.
			p = $urandom_range(0, 1) ? collinear_pair() :
				make_pair(grid_coord(), grid_coord(), grid_coord(), grid_coord(),
					grid_coord(), grid_coord(), grid_coord(), grid_coord());
			p.a_end_x = p.a_start_x;
			p.a_end_y = p.a_start_y;
			if ($urandom_range(0, 2) == 0) begin
				p.b_end_x = p.b_start_x;
				p.b_end_y = p.b_start_y;
			end
		end else begin
			p = make_pair(extreme_coord(), extreme_coord(), extreme_coord(),
				extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
				extreme_coord());
		end
		return p;
	endfunction

	// Stimulus: a short directed set first, then the random mix. The whole list is
	// queued at time zero; the driver below paces it out.
	initial begin
		// Plain crossings, a parallel miss, a T junction, a shared endpoint and a perpendicular miss.
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
		pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
		pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 7));
		pending_pairs.push_back(make_pair(0, 0, 4, 4, 4, 4, 9, 1));
		pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 1, 5, 9));
		pending_pairs.push_back(make_pair(10, 0, 0, 10, 10, 10, 0, 0));
		// Collinear segments: overlap, gap, touching ends, containment, behind.
		pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
		pending_pairs.push_back(make_pair(0, 0, 4, 0, 6, 0, 9, 0));
		pending_pairs.push_back(make_pair(0, 0, 4, 4, 4, 4, 8, 8));
		pending_pairs.push_back(make_pair(10, 10, 0, 0, 2, 2, 3, 3));
		pending_pairs.push_back(make_pair(0, 0, 3, 3, -5, -5, -1, -1));
		pending_pairs.push_back(make_pair(5, -3, 5, 3, 5, 3, 5, 9));
		// Degenerate segments: a point on, beyond and equal to the other, and two distinct points.
		pending_pairs.push_back(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
		pending_pairs.push_back(make_pair(9, 9, 9, 9, 0, 0, 6, 6));
		pending_pairs.push_back(make_pair(7, -2, 7, -2, 7, -2, 7, -2));
		pending_pairs.push_back(make_pair(7, -2, 7, -2, 7, -3, 7, -3));
		// Extremes of the coordinate range, including the largest cross products.
		pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
			-32768, 32767, 32767, -32768));
		pending_pairs.push_back(make_pair(-32768, 32767, 32767, 32767,
			0, 32767, 32767, 32767));
		pending_pairs.push_back(make_pair(-32768, -32768, -32767, -32768,
			32767, 32767, 32766, 32767));
		pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
			-32768, -32768, 32767, 32767));
		pending_pairs.push_back(make_pair(-32768, -32768, 32767, -32768,
			-32768, 32767, 32767, -32767));
		pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
			32767, 32767, 32767, 32767));
		pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768));
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			pending_pairs.push_back(random_pair());
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Sample on the falling edge, clear of the updates made at the rising one.
		@(negedge clk);
		while (pending_pairs.size() != 0 || in_valid || expected_verdicts.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Sender. Pairs go out in bursts of random length separated by random gaps;
	// now and then a long burst runs with no gap at all. The expected verdict is
	// worked out from the payload on the port at the very edge of the transfer.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		seg_pair_t next_pair;
		logic      load_next;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			load_next = 1'b0;
			if (in_valid && in_ready) begin
				expected_verdicts.push_back(predict_intersects('{a_start_x, a_start_y,
					a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y}));
			end
			// The payload may only change once the current pair has gone.
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_pairs.size() != 0) begin
					load_next = 1'b1;
				end
			end
			if (load_next) begin
				next_pair = pending_pairs.pop_front();
				a_start_x <= next_pair.a_start_x;
				a_start_y <= next_pair.a_start_y;
				a_end_x   <= next_pair.a_end_x;
				a_end_y   <= next_pair.a_end_y;
				b_start_x <= next_pair.b_start_x;
				b_start_y <= next_pair.b_start_y;
				b_end_x   <= next_pair.b_end_x;
				b_end_y   <= next_pair.b_end_y;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					if ($urandom_range(0, 7) == 0) begin
						burst_left = $urandom_range(100, 300);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 2) == 0) ?
							$urandom_range(4, 12) : $urandom_range(1, 3);
					end
				end
			end
			in_valid <= load_next || (in_valid && !in_ready);
		end
	end

	// Receiver. Ready runs and stalls alternate, each of random length, so that
	// the back pressure reaches every stage of the pipeline and sometimes fills it.
	// Each verdict that arrives is matched with the oldest one still expected.
	int ready_run = 0;
	int stall_run = 0;

	always @(posedge clk or negedge arst_n) begin
		logic verdict_due;
		logic ready_next;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("intersects: unexpected transfer, expected none, actual %0b",
						intersects);
					error_count++;
				end else begin
					verdict_due = expected_verdicts.pop_front();
					if (intersects !== verdict_due) begin
						$error("intersects: expected %0b, actual %0b", verdict_due,
							intersects);
						error_count++;
					end
				end
			end
			if (ready_run > 0) begin
				ready_run--;
				ready_next = 1'b1;
			end else if (stall_run > 0) begin
				stall_run--;
				ready_next = 1'b0;
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						ready_run = $urandom_range(100, 200);
						stall_run = $urandom_range(0, 2);
					end
					1: begin
						ready_run = $urandom_range(0, 1);
						stall_run = $urandom_range(0, 1);
					end
					2: begin
						ready_run = $urandom_range(1, 40);
						stall_run = $urandom_range(10, 20);
					end
					default: begin
						ready_run = $urandom_range(1, 40);
						stall_run = $urandom_range(1, 6);
					end
				endcase
				ready_next = 1'b1;
			end
			out_ready <= ready_next;
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
